[hdl/clce_pkg.sv]
// Shared types, constants and helpers for the circular list cursor engine.
// No dependencies; used by circular_list_cursor_engine.
`default_nettype none

package clce_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int NSLOTS     = CAPACITY + 1;
    localparam int PTR_W      = $clog2(NSLOTS);
    localparam int POS_W      = 6;
    localparam int CNT_W      = 7;

    typedef enum logic [3:0] {
        OP_HEAD       = 4'd0,
        OP_NEXT       = 4'd1,
        OP_PRIOR      = 4'd2,
        OP_READ       = 4'd3,
        OP_INS_AFTER  = 4'd4,
        OP_INS_BEFORE = 4'd5,
        OP_REMOVE     = 4'd6,
        OP_FIND       = 4'd7,
        OP_LENGTH     = 4'd8,
        OP_TRAVERSE   = 4'd9,
        OP_CLEAR      = 4'd10,
        OP_JOSEPHUS   = 4'd11
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_SENTINEL  = 3'd4,
        ST_BAD_ROUND = 3'd5
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_NX1,
        S_RD1,
        S_PRED,
        S_L0,
        S_L1,
        S_L2,
        S_L3,
        S_U0,
        S_U1,
        S_U2,
        S_FIND,
        S_TRAV,
        S_JR,
        S_JS,
        S_JS1,
        S_EMIT
    } t_state;

    // Link value of a slot that has not been written since reset or clear:
    // sentinel points to itself, item slots are chained free in order.
    function automatic logic [PTR_W-1:0] reset_link(input logic [PTR_W-1:0] a);
        logic [PTR_W-1:0] r;
        if (a == PTR_W'(0) || a == PTR_W'(CAPACITY)) begin
            r = '0;
        end else begin
            r = a + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/circular_list_cursor_engine.sv]
// Circular list cursor engine: sentinel-based singly linked list in slot memories.
// Depends on clce_pkg.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_ready     | i_op i_value i_rounds i_step_count
//  out     | output    | o_out_valid / i_out_ready   | o_status o_item o_position
//          |           |                             | o_list_length o_last
//
// One item at a time. Memory reads are registered, so every access is read-then-use:
// head, length and clear need no read; prior, insert before and remove walk the link
// memory one slot per cycle, find likewise, traverse one slot per cycle while the
// output is not stalled, and Josephus walks the step count then unlinks per round.
// Reset is synchronous; link memory returns to its reset image through per-slot
// valid bits, so no clearing pass is needed. A stalled output beat holds the engine.
`default_nettype none

module circular_list_cursor_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_op,
    input  wire logic [31:0] i_value,
    input  wire logic [6:0]  i_rounds,
    input  wire logic [7:0]  i_step_count,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [31:0]      o_item,
    output logic [5:0]       o_position,
    output logic [6:0]       o_list_length,
    output logic             o_last
);

    localparam int PW = clce_pkg::PTR_W;
    localparam int DW = clce_pkg::DATA_WIDTH;
    localparam int CW = clce_pkg::CNT_W;
    localparam int QW = clce_pkg::POS_W;

    // slot memories
    logic [PW-1:0] r_next_mem [clce_pkg::NSLOTS];
    logic [DW-1:0] r_data_mem [clce_pkg::NSLOTS];
    logic [clce_pkg::NSLOTS-1:0] r_vld;

    clce_pkg::t_state r_state, n_state;
    clce_pkg::t_op    r_op, n_op;
    logic [DW-1:0]    r_val, n_val;
    logic [6:0]       r_rounds, n_rounds;
    logic [7:0]       r_k, n_k;
    logic [PW-1:0]    r_cursor, n_cursor;
    logic [PW-1:0]    r_free, n_free;
    logic [CW-1:0]    r_count, n_count;
    logic [PW-1:0]    r_head;
    logic [PW-1:0]    r_p, n_p;
    logic [PW-1:0]    r_at, n_at;
    logic [PW-1:0]    r_s, n_s;
    logic [PW-1:0]    r_nc, n_nc;
    logic [CW-1:0]    r_i, n_i;
    logic [7:0]       r_j, n_j;
    clce_pkg::t_status r_st, n_st;
    logic [DW-1:0]    r_item, n_item;
    logic [QW-1:0]    r_pos, n_pos;
    logic             r_last, n_last;

    logic [PW-1:0]    r_nx_q;
    logic [DW-1:0]    r_dt_q;

    logic             r_ovld;
    logic [2:0]       r_o_st;
    logic [DW-1:0]    r_o_item;
    logic [QW-1:0]    r_o_pos;
    logic [CW-1:0]    r_o_len;
    logic             r_o_last;

    // memory and output controls
    logic             rd_en;
    logic [PW-1:0]    rd_addr;
    logic             nw_en;
    logic [PW-1:0]    nw_addr;
    logic [PW-1:0]    nw_data;
    logic             dw_en;
    logic             clr;
    logic             ld;
    clce_pkg::t_status ld_st;
    logic [DW-1:0]    ld_item;
    logic [QW-1:0]    ld_pos;
    logic             ld_last;

    logic accept;
    logic can_emit;
    logic trav_last;
    logic [PW-1:0] jump_nx;

    assign o_in_ready = (r_state == clce_pkg::S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign can_emit   = !r_ovld || i_out_ready;
    assign trav_last  = (r_nx_q == '0) || (r_i == CW'(clce_pkg::CAPACITY - 1));
    assign jump_nx    = (r_nx_q == '0) ? r_head : r_nx_q;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            clce_pkg::S_IDLE: begin
                if (accept) n_state = clce_pkg::S_DISP;
            end
            clce_pkg::S_DISP: begin
                case (r_op)
                    clce_pkg::OP_NEXT: begin
                        n_state = (r_count == '0) ? clce_pkg::S_EMIT : clce_pkg::S_NX1;
                    end
                    clce_pkg::OP_PRIOR: begin
                        n_state = (r_count == '0) ? clce_pkg::S_EMIT : clce_pkg::S_PRED;
                    end
                    clce_pkg::OP_READ: begin
                        n_state = (r_count == '0 || r_cursor == '0) ? clce_pkg::S_EMIT
                                                                    : clce_pkg::S_RD1;
                    end
                    clce_pkg::OP_INS_AFTER: begin
                        n_state = (r_count >= CW'(clce_pkg::CAPACITY)) ? clce_pkg::S_EMIT
                                                                       : clce_pkg::S_L0;
                    end
                    clce_pkg::OP_INS_BEFORE: begin
                        n_state = (r_count == '0 || r_count >= CW'(clce_pkg::CAPACITY))
                                  ? clce_pkg::S_EMIT : clce_pkg::S_PRED;
                    end
                    clce_pkg::OP_REMOVE: begin
                        n_state = (r_count == '0 || r_cursor == '0) ? clce_pkg::S_EMIT
                                                                    : clce_pkg::S_PRED;
                    end
                    clce_pkg::OP_FIND: begin
                        n_state = (r_count == '0) ? clce_pkg::S_EMIT : clce_pkg::S_FIND;
                    end
                    clce_pkg::OP_TRAVERSE: begin
                        n_state = (r_count == '0) ? clce_pkg::S_EMIT : clce_pkg::S_TRAV;
                    end
                    clce_pkg::OP_JOSEPHUS: begin
                        n_state = (r_rounds >= r_count || r_rounds == '0) ? clce_pkg::S_EMIT
                                                                          : clce_pkg::S_JR;
                    end
                    default: n_state = clce_pkg::S_EMIT;
                endcase
            end
            clce_pkg::S_NX1:  n_state = clce_pkg::S_EMIT;
            clce_pkg::S_RD1:  n_state = clce_pkg::S_EMIT;
            clce_pkg::S_PRED: begin
                if (r_nx_q == r_cursor) begin
                    case (r_op)
                        clce_pkg::OP_PRIOR:      n_state = clce_pkg::S_EMIT;
                        clce_pkg::OP_INS_BEFORE: n_state = clce_pkg::S_L0;
                        default:                 n_state = clce_pkg::S_U0;
                    endcase
                end
            end
            clce_pkg::S_L0:   n_state = clce_pkg::S_L1;
            clce_pkg::S_L1:   n_state = clce_pkg::S_L2;
            clce_pkg::S_L2:   n_state = clce_pkg::S_L3;
            clce_pkg::S_L3:   n_state = clce_pkg::S_EMIT;
            clce_pkg::S_U0:   n_state = clce_pkg::S_U1;
            clce_pkg::S_U1:   n_state = clce_pkg::S_U2;
            clce_pkg::S_U2:   n_state = clce_pkg::S_EMIT;
            clce_pkg::S_FIND: begin
                if (r_dt_q == r_val || trav_last) n_state = clce_pkg::S_EMIT;
            end
            clce_pkg::S_TRAV: begin
                if (can_emit && trav_last) n_state = clce_pkg::S_IDLE;
            end
            clce_pkg::S_JR:   n_state = clce_pkg::S_JS;
            clce_pkg::S_JS: begin
                n_state = (r_j < r_k) ? clce_pkg::S_JS1 : clce_pkg::S_PRED;
            end
            clce_pkg::S_JS1:  n_state = clce_pkg::S_JS;
            clce_pkg::S_EMIT: begin
                if (can_emit) n_state = r_last ? clce_pkg::S_IDLE : clce_pkg::S_JR;
            end
            default: n_state = clce_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_op     = r_op;
        n_val    = r_val;
        n_rounds = r_rounds;
        n_k      = r_k;
        n_cursor = r_cursor;
        n_free   = r_free;
        n_count  = r_count;
        n_p      = r_p;
        n_at     = r_at;
        n_s      = r_s;
        n_nc     = r_nc;
        n_i      = r_i;
        n_j      = r_j;
        n_st     = r_st;
        n_item   = r_item;
        n_pos    = r_pos;
        n_last   = r_last;
        rd_en    = 1'b0;
        rd_addr  = r_cursor;
        nw_en    = 1'b0;
        nw_addr  = r_at;
        nw_data  = r_s;
        dw_en    = 1'b0;
        clr      = 1'b0;
        ld       = 1'b0;
        ld_st    = r_st;
        ld_item  = r_item;
        ld_pos   = r_pos;
        ld_last  = r_last;

        case (r_state)
            clce_pkg::S_IDLE: begin
                if (accept) begin
                    n_op     = clce_pkg::t_op'(i_op);
                    n_val    = i_value;
                    n_rounds = i_rounds;
                    n_k      = i_step_count;
                    n_st     = clce_pkg::ST_OK;
                    n_item   = '0;
                    n_pos    = '0;
                    n_last   = 1'b1;
                end
            end
            clce_pkg::S_DISP: begin
                case (r_op)
                    clce_pkg::OP_HEAD: begin
                        n_cursor = r_head;
                        if (r_count == '0) n_st = clce_pkg::ST_EMPTY;
                    end
                    clce_pkg::OP_NEXT: begin
                        if (r_count == '0) begin
                            n_st = clce_pkg::ST_EMPTY;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_cursor;
                        end
                    end
                    clce_pkg::OP_PRIOR: begin
                        if (r_count == '0) begin
                            n_st = clce_pkg::ST_EMPTY;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_p     = '0;
                        end
                    end
                    clce_pkg::OP_READ: begin
                        if (r_count == '0) begin
                            n_st = clce_pkg::ST_EMPTY;
                        end else if (r_cursor == '0) begin
                            n_st = clce_pkg::ST_SENTINEL;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_cursor;
                        end
                    end
                    clce_pkg::OP_INS_AFTER: begin
                        if (r_count >= CW'(clce_pkg::CAPACITY)) begin
                            n_st = clce_pkg::ST_FULL;
                        end else begin
                            n_at = r_cursor;
                        end
                    end
                    clce_pkg::OP_INS_BEFORE: begin
                        if (r_count == '0) begin
                            n_st = clce_pkg::ST_EMPTY;
                        end else if (r_count >= CW'(clce_pkg::CAPACITY)) begin
                            n_st = clce_pkg::ST_FULL;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_p     = '0;
                        end
                    end
                    clce_pkg::OP_REMOVE: begin
                        if (r_count == '0) begin
                            n_st = clce_pkg::ST_EMPTY;
                        end else if (r_cursor == '0) begin
                            n_st = clce_pkg::ST_SENTINEL;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_p     = '0;
                        end
                    end
                    clce_pkg::OP_FIND, clce_pkg::OP_TRAVERSE: begin
                        if (r_count == '0) begin
                            n_st = clce_pkg::ST_EMPTY;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_head;
                            n_i     = '0;
                        end
                    end
                    clce_pkg::OP_CLEAR: begin
                        clr      = 1'b1;
                        n_free   = PW'(1);
                        n_count  = '0;
                        n_cursor = '0;
                    end
                    clce_pkg::OP_JOSEPHUS: begin
                        if (r_rounds >= r_count) begin
                            n_st = clce_pkg::ST_BAD_ROUND;
                        end else if (r_rounds != '0) begin
                            n_cursor = r_head;
                            n_i      = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            clce_pkg::S_NX1: n_cursor = r_nx_q;
            clce_pkg::S_RD1: n_item = r_dt_q;
            clce_pkg::S_PRED: begin
                if (r_nx_q == r_cursor) begin
                    if (r_op == clce_pkg::OP_PRIOR) n_cursor = r_p;
                    else                            n_at     = r_p;
                end else begin
                    n_p     = r_nx_q;
                    rd_en   = 1'b1;
                    rd_addr = r_nx_q;
                end
            end
            // link a free slot after r_at
            clce_pkg::S_L0: begin
                n_s     = r_free;
                rd_en   = 1'b1;
                rd_addr = r_free;
            end
            clce_pkg::S_L1: begin
                n_free  = r_nx_q;
                rd_en   = 1'b1;
                rd_addr = r_at;
            end
            clce_pkg::S_L2: begin
                nw_en   = 1'b1;
                nw_addr = r_s;
                nw_data = r_nx_q;
                dw_en   = 1'b1;
            end
            clce_pkg::S_L3: begin
                nw_en   = 1'b1;
                nw_addr = r_at;
                nw_data = r_s;
                n_count = r_count + CW'(1);
            end
            // unlink the cursor slot, r_at holds its predecessor
            clce_pkg::S_U0: begin
                rd_en   = 1'b1;
                rd_addr = r_cursor;
            end
            clce_pkg::S_U1: begin
                n_item  = r_dt_q;
                n_nc    = r_nx_q;
                nw_en   = 1'b1;
                nw_addr = r_at;
                nw_data = r_nx_q;
            end
            clce_pkg::S_U2: begin
                nw_en    = 1'b1;
                nw_addr  = r_cursor;
                nw_data  = r_free;
                n_free   = r_cursor;
                n_count  = r_count - CW'(1);
                n_cursor = r_nc;
                if (r_op == clce_pkg::OP_JOSEPHUS) begin
                    n_last = (r_i + CW'(1) == r_rounds);
                    n_i    = r_i + CW'(1);
                end
            end
            clce_pkg::S_FIND: begin
                if (r_dt_q == r_val) begin
                    n_item = r_dt_q;
                    n_pos  = r_i[QW-1:0];
                end else if (trav_last) begin
                    n_st = clce_pkg::ST_NOT_FOUND;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_nx_q;
                    n_i     = r_i + CW'(1);
                end
            end
            clce_pkg::S_TRAV: begin
                if (can_emit) begin
                    ld      = 1'b1;
                    ld_st   = clce_pkg::ST_OK;
                    ld_item = r_dt_q;
                    ld_pos  = r_i[QW-1:0];
                    ld_last = trav_last;
                    if (!trav_last) begin
                        rd_en   = 1'b1;
                        rd_addr = r_nx_q;
                        n_i     = r_i + CW'(1);
                    end
                end
            end
            // new round: the sentinel is never counted
            clce_pkg::S_JR: begin
                if (r_cursor == '0) n_cursor = r_head;
                n_j = 8'd1;
            end
            clce_pkg::S_JS: begin
                rd_en = 1'b1;
                if (r_j < r_k) begin
                    rd_addr = r_cursor;
                end else begin
                    rd_addr = '0;
                    n_p     = '0;
                end
            end
            clce_pkg::S_JS1: begin
                n_cursor = jump_nx;
                n_j      = r_j + 8'd1;
            end
            clce_pkg::S_EMIT: begin
                if (can_emit) begin
                    ld = 1'b1;
                    if (!r_last) begin
                        n_st   = clce_pkg::ST_OK;
                        n_item = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // slot memories, one read and one write per cycle
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_nx_q <= r_vld[rd_addr] ? r_next_mem[rd_addr] : clce_pkg::reset_link(rd_addr);
            r_dt_q <= r_data_mem[rd_addr];
        end
        if (nw_en) begin
            r_next_mem[nw_addr] <= nw_data;
        end
        if (dw_en) begin
            r_data_mem[r_s] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr) begin
            r_vld  <= '0;
            r_head <= '0;
        end else if (nw_en) begin
            r_vld[nw_addr] <= 1'b1;
            if (nw_addr == '0) r_head <= nw_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= clce_pkg::S_IDLE;
            r_cursor <= '0;
            r_free   <= PW'(1);
            r_count  <= '0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_free   <= n_free;
            r_count  <= n_count;
            if (ld)               r_ovld <= 1'b1;
            else if (i_out_ready) r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_rounds <= n_rounds;
        r_k      <= n_k;
        r_p      <= n_p;
        r_at     <= n_at;
        r_s      <= n_s;
        r_nc     <= n_nc;
        r_i      <= n_i;
        r_j      <= n_j;
        r_st     <= n_st;
        r_item   <= n_item;
        r_pos    <= n_pos;
        r_last   <= n_last;
        if (ld) begin
            r_o_st   <= ld_st;
            r_o_item <= ld_item;
            r_o_pos  <= ld_pos;
            r_o_len  <= r_count;
            r_o_last <= ld_last;
        end
    end

    assign o_out_valid   = r_ovld;
    assign o_status      = r_o_st;
    assign o_item        = r_o_item;
    assign o_position    = r_o_pos;
    assign o_list_length = r_o_len;
    assign o_last        = r_o_last;

endmodule

`default_nettype wire
